@@ sv/bts_pkg.sv @@
// shared constants and codes for the bilinear texel sampler
`default_nettype none

package bts_pkg;

    // default image store dimensions
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // action codes of an input beat
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // field widths
    localparam int DIM_W   = 9;
    localparam int COORD_W = 16;
    localparam int UV_W    = 17;
    localparam int TEXEL_W = 16;
    localparam int FRAC_W  = 16;

    // shared multiplier: 32 x 17 into a 49-bit product
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 1.0 in unsigned Q1.16
    localparam logic [UV_W-1:0] ONE_Q16 = 17'h10000;

endpackage

`default_nettype wire

@@ sv/bilinear_texel_sampler_16bit.sv @@
// top level: texel store, coordinate setup and shared multiply sequencer
//
// The block holds a 16-bit grayscale image of up to MAX_WIDTH x MAX_HEIGHT texels in a
// single-port store addressed as y*width+x and handles one beat at a time: item_ready is
// high only while the block is idle. A write passes the row offset and store states; beats
// outside the image, action code 3 and writes to an empty image give no result. A read
// passes the row offset, store and read-data states, a bilinear sample the coordinate,
// row offset, fetch and interpolation states; an empty image gives 0 in the cycle after
// acceptance. The result stays on result_value until taken. The sequence follows from one
// 32x17 multiplier doing the coordinate scaling, both row offsets and all six interpolation
// products in turn, and from the single store port that fetches the four neighbour texels
// one per cycle. Texels are undefined after reset until written; there is no clearing pass.
`default_nettype none

module bilinear_texel_sampler_16bit
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_write,
    input  wire logic                 cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    // input channel
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [1:0]           action,
    input  wire logic [COORD_W-1:0]   x_coord,
    input  wire logic [COORD_W-1:0]   y_coord,
    input  wire logic [UV_W-1:0]      u_coord,
    input  wire logic [UV_W-1:0]      v_coord,
    input  wire logic [TEXEL_W-1:0]   write_value,
    // result channel
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic [TEXEL_W-1:0]        result_value
);

    localparam int XI_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YI_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [16:0] {
        ST_IDLE = 17'h00001,
        ST_XP   = 17'h00002,
        ST_YP   = 17'h00004,
        ST_YL   = 17'h00008,
        ST_R0   = 17'h00010,
        ST_R1   = 17'h00020,
        ST_MEM  = 17'h00040,
        ST_RDAT = 17'h00080,
        ST_A00  = 17'h00100,
        ST_A10  = 17'h00200,
        ST_A01  = 17'h00400,
        ST_A11  = 17'h00800,
        ST_T11  = 17'h01000,
        ST_BOT  = 17'h02000,
        ST_FIN1 = 17'h04000,
        ST_FIN2 = 17'h08000,
        ST_OUT  = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;

    // payload and datapath registers
    logic [1:0]         action_reg;
    logic [TEXEL_W-1:0] wval_reg;
    logic [UV_W-1:0]    u_reg;
    logic [UV_W-1:0]    v_reg;
    logic [XI_W-1:0]    x0_reg;
    logic [XI_W-1:0]    x1_reg;
    logic [YI_W-1:0]    y0_reg;
    logic [YI_W-1:0]    y1_reg;
    logic [FRAC_W-1:0]  dx_reg;
    logic [FRAC_W-1:0]  dy_reg;
    logic [MUL_B_W-1:0] wx0_reg;
    logic [MUL_B_W-1:0] wy0_reg;
    logic [ADDR_W-1:0]  row0_reg;
    logic [ADDR_W-1:0]  row1_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [MUL_A_W-1:0] top_reg;
    logic [MUL_A_W-1:0] bot_reg;
    logic [TEXEL_W-1:0] out_reg;
    logic [TEXEL_W-1:0] rdata_reg;

    // texel store
    logic [TEXEL_W-1:0] texel_mem [DEPTH];

    logic [WD_W-1:0]    w_eff;
    logic [HD_W-1:0]    h_eff;
    logic [WD_W-1:0]    w_m1;
    logic [HD_W-1:0]    h_m1;
    logic               empty;
    logic               in_bounds;
    logic [XI_W-1:0]    x_clamp;
    logic [YI_W-1:0]    y_clamp;
    logic               accept;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  acc_sum;

    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;

    // effective dimensions, oversized registers fall back to the store size
    assign w_eff = (32'(image_width_reg) > 32'(MAX_WIDTH))
                   ? WD_W'(MAX_WIDTH) : WD_W'(image_width_reg);
    assign h_eff = (32'(image_height_reg) > 32'(MAX_HEIGHT))
                   ? HD_W'(MAX_HEIGHT) : HD_W'(image_height_reg);
    assign w_m1  = w_eff - WD_W'(1);
    assign h_m1  = h_eff - HD_W'(1);
    assign empty = (w_eff == '0) || (h_eff == '0);

    // clamp to edge, equals the raw coordinate when inside the image
    assign in_bounds = (32'(x_coord) < 32'(w_eff)) && (32'(y_coord) < 32'(h_eff));
    assign x_clamp   = (32'(x_coord) > 32'(w_m1)) ? XI_W'(w_m1) : XI_W'(x_coord);
    assign y_clamp   = (32'(y_coord) > 32'(h_m1)) ? YI_W'(h_m1) : YI_W'(y_coord);

    assign accept       = item_valid && item_ready;
    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);
    assign result_value = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  image_width_reg  <= cfg_data;
                REG_HEIGHT: image_height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (action)
                        ACT_WRITE:  state_next = (!empty && in_bounds) ? ST_R0 : ST_IDLE;
                        ACT_READ:   state_next = empty ? ST_OUT : ST_R0;
                        ACT_SAMPLE: state_next = empty ? ST_OUT : ST_XP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_XP:   state_next = ST_YP;
            ST_YP:   state_next = ST_YL;
            ST_YL:   state_next = ST_R0;
            ST_R0:   state_next = (action_reg == ACT_SAMPLE) ? ST_R1 : ST_MEM;
            ST_R1:   state_next = ST_A00;
            ST_MEM:  state_next = (action_reg == ACT_WRITE) ? ST_IDLE : ST_RDAT;
            ST_RDAT: state_next = ST_OUT;
            ST_A00:  state_next = ST_A10;
            ST_A10:  state_next = ST_A01;
            ST_A01:  state_next = ST_A11;
            ST_A11:  state_next = ST_T11;
            ST_T11:  state_next = ST_BOT;
            ST_BOT:  state_next = ST_FIN1;
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_OUT;
            ST_OUT:  state_next = result_ready ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_XP:
            begin
                mul_a = MUL_A_W'(u_reg);
                mul_b = MUL_B_W'(w_m1);
            end
            ST_YP:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'(h_m1);
            end
            ST_R0:
            begin
                mul_a = MUL_A_W'(y0_reg);
                mul_b = MUL_B_W'(w_eff);
            end
            ST_R1:
            begin
                mul_a = MUL_A_W'(y1_reg);
                mul_b = MUL_B_W'(w_eff);
            end
            ST_A10, ST_A11:
            begin
                mul_a = MUL_A_W'(rdata_reg);
                mul_b = wx0_reg;
            end
            ST_A01, ST_T11:
            begin
                mul_a = MUL_A_W'(rdata_reg);
                mul_b = MUL_B_W'(dx_reg);
            end
            ST_BOT:
            begin
                mul_a = top_reg;
                mul_b = wy0_reg;
            end
            ST_FIN1:
            begin
                mul_a = bot_reg;
                mul_b = MUL_B_W'(dy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_sum = acc_reg + prod_reg;

    // store address select, one access per cycle
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = '0;
        case (state_reg)
            ST_MEM:
            begin
                mem_addr = prod_reg[ADDR_W-1:0] + ADDR_W'(x0_reg);
                mem_we   = (action_reg == ACT_WRITE);
            end
            ST_A00:  mem_addr = row0_reg + ADDR_W'(x0_reg);
            ST_A10:  mem_addr = row0_reg + ADDR_W'(x1_reg);
            ST_A01:  mem_addr = row1_reg + ADDR_W'(x0_reg);
            ST_A11:  mem_addr = row1_reg + ADDR_W'(x1_reg);
            default: mem_addr = '0;
        endcase
    end

    // texel store port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            texel_mem[mem_addr] <= wval_reg;
        end
        rdata_reg <= texel_mem[mem_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_reg <= action;
                    wval_reg   <= write_value;
                    x0_reg     <= x_clamp;
                    y0_reg     <= y_clamp;
                    u_reg      <= (u_coord > ONE_Q16) ? ONE_Q16 : u_coord;
                    v_reg      <= (v_coord > ONE_Q16) ? ONE_Q16 : v_coord;
                    out_reg    <= '0;
                end
            end
            // x scale is in the product, split into index and fraction
            ST_YP:
            begin
                x0_reg <= prod_reg[FRAC_W +: XI_W];
                dx_reg <= prod_reg[FRAC_W-1:0];
            end
            ST_YL:
            begin
                y0_reg  <= prod_reg[FRAC_W +: YI_W];
                dy_reg  <= prod_reg[FRAC_W-1:0];
                x1_reg  <= (x0_reg == XI_W'(w_m1)) ? x0_reg : x0_reg + XI_W'(1);
                wx0_reg <= ONE_Q16 - MUL_B_W'(dx_reg);
            end
            ST_R0:
            begin
                y1_reg  <= (y0_reg == YI_W'(h_m1)) ? y0_reg : y0_reg + YI_W'(1);
                wy0_reg <= ONE_Q16 - MUL_B_W'(dy_reg);
            end
            ST_R1:   row0_reg <= prod_reg[ADDR_W-1:0];
            ST_A00:  row1_reg <= prod_reg[ADDR_W-1:0];
            ST_A01:  acc_reg  <= prod_reg;
            ST_A11:  top_reg  <= MUL_A_W'(acc_sum);
            ST_T11:  acc_reg  <= prod_reg;
            ST_BOT:  bot_reg  <= MUL_A_W'(acc_sum);
            ST_FIN1: acc_reg  <= prod_reg;
            ST_FIN2: out_reg  <= acc_sum[2*FRAC_W +: TEXEL_W];
            ST_RDAT: out_reg  <= rdata_reg;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/bts_checker.sv @@
// port-level checks for the bilinear texel sampler and their binding
`default_nettype none

module bts_checker
    import bts_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_ready,
    input wire logic [1:0]           action,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire logic [TEXEL_W-1:0]   result_value
);

    // a waiting result beat holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_value))
        else $error("result beat changed while stalled");

    // one item at a time: never ready while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("ready for input while a result waits");

    // an accepted read or sample keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && ((action == ACT_READ) || (action == ACT_SAMPLE))
        |=> !item_ready)
        else $error("ready right after acceptance");

    // a write never produces a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (action == ACT_WRITE) |=> !result_valid)
        else $error("result after a write");

endmodule

bind bilinear_texel_sampler_16bit bts_checker u_bts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_value (result_value)
);

`default_nettype wire

@@ test/tb_bilinear_texel_sampler_16bit.sv @@
// testbench for the bilinear texel sampler: directed table, random beats, self-checking
`timescale 1ns / 100ps

module tb_bilinear_texel_sampler_16bit;
    import bts_pkg::*;

    // unused action code, ignored by the block
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_PHASES = 11;
    localparam int BEATS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

    // one input beat
    typedef struct packed {
        logic [1:0]          act;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [UV_W-1:0]     u;
        logic [UV_W-1:0]     v;
        logic [TEXEL_W-1:0]  wval;
    } texel_beat_t;

    // one row of the directed table, with image size and an optional typed result
    typedef struct packed {
        logic [DIM_W-1:0]    dim_w;
        logic [DIM_W-1:0]    dim_h;
        logic [1:0]          act;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [UV_W-1:0]     u;
        logic [UV_W-1:0]     v;
        logic [TEXEL_W-1:0]  wval;
        logic                typed;
        logic [TEXEL_W-1:0]  typed_value;
    } directed_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic                cfg_index;
    logic [DIM_W-1:0]    cfg_data;
    logic                item_valid;
    logic                item_ready;
    logic [1:0]          action;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic [UV_W-1:0]     u_coord;
    logic [UV_W-1:0]     v_coord;
    logic [TEXEL_W-1:0]  write_value;
    logic                result_valid;
    logic                result_ready;
    logic [TEXEL_W-1:0]  result_value;

    // shadow image and registers of the predictor
    logic [TEXEL_W-1:0]  model_texels [0:STORE_DEPTH-1];
    bit                  texel_written [0:STORE_DEPTH-1];
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    // texel results still to come, oldest first
    logic [TEXEL_W-1:0]  pending_texels [$];

    directed_row_t       directed_rows [0:DIRECTED_ROWS-1];
    int unsigned         phase_w [0:RANDOM_PHASES-1] = '{1, 4, 256, 7, 2, 256, 5, 0, 300, 8, 16};
    int unsigned         phase_h [0:RANDOM_PHASES-1] = '{1, 4, 256, 0, 256, 1, 9, 3, 5, 511, 3};

    bit                  no_idle;
    int unsigned         mismatch_count;
    int unsigned         results_checked;
    int unsigned         writes_sent;
    int unsigned         reads_sent;
    int unsigned         samples_sent;
    int unsigned         ignored_sent;
    int unsigned         cycle_count;

    bilinear_texel_sampler_16bit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .u_coord      (u_coord),
        .v_coord      (v_coord),
        .write_value  (write_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_value (result_value)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] r);
        return (r > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(r);
    endfunction

    // store index of (x,y) clamped to the image edge
    function automatic int unsigned clamp_index(input int unsigned x, input int unsigned y,
                                                input int unsigned w, input int unsigned h);
        if (x > w - 1) x = w - 1;
        if (y > h - 1) y = h - 1;
        return y * w + x;
    endfunction

    // four neighbour indexes and the fractions of a bilinear sample
    function automatic void sample_corners(input logic [UV_W-1:0] u, input logic [UV_W-1:0] v,
                                           input int unsigned w, input int unsigned h,
                                           output int unsigned i00, output int unsigned i10,
                                           output int unsigned i01, output int unsigned i11,
                                           output int unsigned fx, output int unsigned fy);
        int unsigned us, vs, xp, yp, x0, y0, x1, y1;
        us = (u > ONE_Q16) ? ONE_Q16 : u;
        vs = (v > ONE_Q16) ? ONE_Q16 : v;
        xp = us * (w - 1);
        yp = vs * (h - 1);
        x0 = xp >> FRAC_W;
        y0 = yp >> FRAC_W;
        fx = xp & 32'hFFFF;
        fy = yp & 32'hFFFF;
        x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
        i00 = y0 * w + x0;
        i10 = y0 * w + x1;
        i01 = y1 * w + x0;
        i11 = y1 * w + x1;
    endfunction

    // true when every texel the beat fetches has been written; else names one that has not
    function automatic bit footprint_written(input texel_beat_t b, output int unsigned missing);
        int unsigned w, h, i00, i10, i01, i11, fx, fy;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        missing = 0;
        if (w == 0 || h == 0)
            return 1'b1;
        if (b.act == ACT_READ)
        begin
            i00 = clamp_index(b.x, b.y, w, h);
            i10 = i00;
            i01 = i00;
            i11 = i00;
        end
        else if (b.act == ACT_SAMPLE)
            sample_corners(b.u, b.v, w, h, i00, i10, i01, i11, fx, fy);
        else
            return 1'b1;
        if (!texel_written[i00]) missing = i00;
        else if (!texel_written[i10]) missing = i10;
        else if (!texel_written[i01]) missing = i01;
        else if (!texel_written[i11]) missing = i11;
        return texel_written[i00] && texel_written[i10] && texel_written[i01] && texel_written[i11];
    endfunction

    // texel result of one beat, updating the shadow image on writes
    task automatic predict_texel_beat(input texel_beat_t b, output bit produces,
                                      output bit took_effect, output logic [TEXEL_W-1:0] texel);
        int unsigned w, h, idx, i00, i10, i01, i11, fx, fy;
        longint unsigned top, bot, sum;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        produces = 1'b0;
        took_effect = 1'b0;
        texel = '0;
        case (b.act)
            ACT_WRITE:
            begin
                if (b.x < w && b.y < h)
                begin
                    idx = b.y * w + b.x;
                    model_texels[idx] = b.wval;
                    texel_written[idx] = 1'b1;
                    took_effect = 1'b1;
                end
            end
            ACT_READ:
            begin
                produces = 1'b1;
                took_effect = 1'b1;
                if (w != 0 && h != 0)
                    texel = model_texels[clamp_index(b.x, b.y, w, h)];
            end
            ACT_SAMPLE:
            begin
                produces = 1'b1;
                took_effect = 1'b1;
                if (w != 0 && h != 0)
                begin
                    sample_corners(b.u, b.v, w, h, i00, i10, i01, i11, fx, fy);
                    top = longint'(model_texels[i00]) * (65536 - fx)
                        + longint'(model_texels[i10]) * fx;
                    bot = longint'(model_texels[i01]) * (65536 - fx)
                        + longint'(model_texels[i11]) * fx;
                    sum = top * (65536 - fy) + bot * fy;
                    texel = TEXEL_W'(sum >> 32);
                end
            end
            default: ;
        endcase
    endtask

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic note_mismatch(input string what, input logic [TEXEL_W-1:0] want,
                                 input logic [TEXEL_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s) at %0t: expected %h, got %h", what, $realtime, want, got);
    endtask

    // present one beat after a random gap, then record its expected result
    task automatic send_beat(input texel_beat_t b, input bit typed,
                             input logic [TEXEL_W-1:0] typed_value, output bit took_effect);
        int unsigned gap;
        bit produces;
        logic [TEXEL_W-1:0] texel;
        gap = draw_gap();
        if (gap != 0)
        begin
            @(negedge clk) item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        action <= b.act;
        x_coord <= b.x;
        y_coord <= b.y;
        u_coord <= b.u;
        v_coord <= b.v;
        write_value <= b.wval;
        do
            @(posedge clk);
        while (!item_ready);
        predict_texel_beat(b, produces, took_effect, texel);
        if (produces)
            pending_texels.push_back(typed ? typed_value : texel);
        case (b.act)
            ACT_WRITE:  writes_sent++;
            ACT_READ:   reads_sent++;
            ACT_SAMPLE: samples_sent++;
            default:    ignored_sent++;
        endcase
    endtask

    // hold off the sender until every expected result has been taken
    task automatic wait_results_drained();
        @(negedge clk) item_valid <= 1'b0;
        while (pending_texels.size() != 0)
            @(posedge clk);
    endtask

    // reprogram the image size once the block is idle
    task automatic set_image_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_results_drained();
        repeat (20) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_write <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    function automatic logic [UV_W-1:0] pick_uv();
        case ($urandom_range(0, 2))
            0: return UV_W'($urandom);
            1: return UV_W'($urandom_range(0, 65536));
            default: return $urandom_range(0, 1) ? UV_W'($urandom_range(65236, 65536))
                                                 : UV_W'($urandom_range(0, 300));
        endcase
    endfunction

    // random beat; reads and samples only touch texels written so far
    task automatic make_random_beat(output texel_beat_t b);
        int unsigned w, h, pick, missing;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        b.x = COORD_W'($urandom);
        b.y = COORD_W'($urandom);
        b.u = UV_W'($urandom);
        b.v = UV_W'($urandom);
        b.wval = TEXEL_W'($urandom);
        missing = 0;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            b.act = ACT_UNUSED;
            return;
        end
        if (pick < 30)
        begin
            b.act = ACT_WRITE;
            if (w != 0 && h != 0 && pick >= 7)
            begin
                b.x = COORD_W'($urandom_range(0, w - 1));
                b.y = COORD_W'($urandom_range(0, h - 1));
            end
            return;
        end
        b.act = (pick < 60) ? ACT_READ : ACT_SAMPLE;
        if (w == 0 || h == 0)
            return;
        for (int tries = 0; tries < 8; tries++)
        begin
            if (b.act == ACT_READ)
            begin
                b.x = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom)
                                                  : COORD_W'($urandom_range(0, w - 1));
                b.y = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom)
                                                  : COORD_W'($urandom_range(0, h - 1));
            end
            else
            begin
                b.u = pick_uv();
                b.v = pick_uv();
            end
            if (footprint_written(b, missing))
                return;
        end
        // fall back to filling the texel that blocked it
        b.act = ACT_WRITE;
        b.x = COORD_W'(missing % w);
        b.y = COORD_W'(missing / w);
    endtask

    // result side: random stalls, compare each beat with the oldest expectation
    initial
    begin : result_monitor
        int unsigned stall;
        logic [TEXEL_W-1:0] want;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk) result_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                results_checked++;
                if (pending_texels.size() == 0)
                    note_mismatch("no result expected", 'x, result_value);
                else
                begin
                    want = pending_texels.pop_front();
                    if (result_value !== want)
                        note_mismatch("result_value", want, result_value);
                end
                stall = draw_gap();
                if (stall != 0)
                begin
                    @(negedge clk) result_ready <= 1'b0;
                    while (!result_valid)
                        @(posedge clk);
                    repeat (stall) @(negedge clk);
                    result_ready <= 1'b1;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        directed_row_t row;
        texel_beat_t beat;
        bit effective;
        int unsigned w, h, counted, xs, ys;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        item_valid = 1'b0;
        action = ACT_WRITE;
        x_coord = '0;
        y_coord = '0;
        u_coord = '0;
        v_coord = '0;
        write_value = '0;
        width_reg = '0;
        height_reg = '0;
        no_idle = 1'b0;

        // directed table: w, h, action, x, y, u, v, write value, typed?, typed result
        // empty image after reset: reads and samples give zero, writes and code 3 ignored
        directed_rows[0]  = '{9'd0, 9'd0, ACT_READ, 16'd0, 16'd0, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'h0000};
        directed_rows[1]  = '{9'd0, 9'd0, ACT_SAMPLE, 16'd0, 16'd0, 17'h1FFFF, 17'h1FFFF,
                              16'h0000, 1'b1, 16'h0000};
        directed_rows[2]  = '{9'd0, 9'd0, ACT_WRITE, 16'd0, 16'd0, 17'd0, 17'd0,
                              16'hFFFF, 1'b0, 16'h0000};
        directed_rows[3]  = '{9'd0, 9'd0, ACT_UNUSED, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF,
                              16'hFFFF, 1'b0, 16'h0000};
        // 3x2 image, filled with extreme and marker values
        directed_rows[4]  = '{9'd3, 9'd2, ACT_WRITE, 16'd0, 16'd0, 17'd0, 17'd0,
                              16'h0000, 1'b0, 16'h0000};
        directed_rows[5]  = '{9'd3, 9'd2, ACT_WRITE, 16'd1, 16'd0, 17'd0, 17'd0,
                              16'hFFFF, 1'b0, 16'h0000};
        directed_rows[6]  = '{9'd3, 9'd2, ACT_WRITE, 16'd2, 16'd0, 17'd0, 17'd0,
                              16'h1234, 1'b0, 16'h0000};
        directed_rows[7]  = '{9'd3, 9'd2, ACT_WRITE, 16'd0, 16'd1, 17'd0, 17'd0,
                              16'h8000, 1'b0, 16'h0000};
        directed_rows[8]  = '{9'd3, 9'd2, ACT_WRITE, 16'd1, 16'd1, 17'd0, 17'd0,
                              16'h0001, 1'b0, 16'h0000};
        directed_rows[9]  = '{9'd3, 9'd2, ACT_WRITE, 16'd2, 16'd1, 17'd0, 17'd0,
                              16'hABCD, 1'b0, 16'h0000};
        directed_rows[10] = '{9'd3, 9'd2, ACT_READ, 16'd0, 16'd0, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'h0000};
        directed_rows[11] = '{9'd3, 9'd2, ACT_READ, 16'd1, 16'd0, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'hFFFF};
        // reads past the edge clamp to the last column and row
        directed_rows[12] = '{9'd3, 9'd2, ACT_READ, 16'hFFFF, 16'hFFFF, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'hABCD};
        // write outside the image is dropped
        directed_rows[13] = '{9'd3, 9'd2, ACT_WRITE, 16'd3, 16'd0, 17'd0, 17'd0,
                              16'h5555, 1'b0, 16'h0000};
        directed_rows[14] = '{9'd3, 9'd2, ACT_READ, 16'hFFFF, 16'd0, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'h1234};
        directed_rows[15] = '{9'd3, 9'd2, ACT_READ, 16'd0, 16'h8000, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'h8000};
        // samples at the corners, saturated, and in between
        directed_rows[16] = '{9'd3, 9'd2, ACT_SAMPLE, 16'd0, 16'd0, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'h0000};
        directed_rows[17] = '{9'd3, 9'd2, ACT_SAMPLE, 16'd0, 16'd0, 17'h10000, 17'h10000,
                              16'h0000, 1'b1, 16'hABCD};
        directed_rows[18] = '{9'd3, 9'd2, ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF,
                              16'h0000, 1'b1, 16'hABCD};
        directed_rows[19] = '{9'd3, 9'd2, ACT_SAMPLE, 16'd0, 16'd0, 17'h08000, 17'h08000,
                              16'h0000, 1'b0, 16'h0000};
        directed_rows[20] = '{9'd3, 9'd2, ACT_SAMPLE, 16'd0, 16'd0, 17'h0FFFF, 17'h00000,
                              16'h0000, 1'b0, 16'h0000};
        // oversized registers act as the full 256x256 store
        directed_rows[21] = '{9'd511, 9'd300, ACT_WRITE, 16'd255, 16'd255, 17'd0, 17'd0,
                              16'h7777, 1'b0, 16'h0000};
        directed_rows[22] = '{9'd511, 9'd300, ACT_READ, 16'hFFFF, 16'hFFFF, 17'd0, 17'd0,
                              16'h0000, 1'b1, 16'h7777};
        directed_rows[23] = '{9'd511, 9'd300, ACT_SAMPLE, 16'd0, 16'd0, 17'h1FFFF, 17'h10000,
                              16'h0000, 1'b1, 16'h7777};
        directed_rows[24] = '{9'd511, 9'd300, ACT_WRITE, 16'd0, 16'd300, 17'd0, 17'd0,
                              16'h1111, 1'b0, 16'h0000};

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed part
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.dim_w != width_reg || row.dim_h != height_reg)
                set_image_dims(row.dim_w, row.dim_h);
            beat.act = row.act;
            beat.x = row.x;
            beat.y = row.y;
            beat.u = row.u;
            beat.v = row.v;
            beat.wval = row.wval;
            send_beat(beat, row.typed, row.typed_value, effective);
        end

        // random part, one image size per phase
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_image_dims(DIM_W'(phase_w[p]), DIM_W'(phase_h[p]));
            no_idle = (p % 4 == 2);
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);

            // fill small images whole, large ones at the four corners
            if (w != 0 && h != 0)
            begin
                for (int cy = 0; cy < 4; cy++)
                begin
                    for (int cx = 0; cx < 4; cx++)
                    begin
                        xs = (cx < 2) ? cx : w + cx - 4;
                        ys = (cy < 2) ? cy : h + cy - 4;
                        if (w * h <= 48 && cx == 0 && cy == 0)
                        begin
                            for (int fy = 0; fy < h; fy++)
                                for (int fx = 0; fx < w; fx++)
                                begin
                                    beat = '{ACT_WRITE, COORD_W'(fx), COORD_W'(fy), 17'd0,
                                             17'd0, TEXEL_W'($urandom)};
                                    send_beat(beat, 1'b0, '0, effective);
                                end
                        end
                        else if (w * h > 48 && xs < w && ys < h)
                        begin
                            beat = '{ACT_WRITE, COORD_W'(xs), COORD_W'(ys), 17'd0, 17'd0,
                                     TEXEL_W'($urandom)};
                            send_beat(beat, 1'b0, '0, effective);
                        end
                    end
                end
            end

            counted = 0;
            while (counted < BEATS_PER_PHASE)
            begin
                make_random_beat(beat);
                send_beat(beat, 1'b0, '0, effective);
                if (effective)
                    counted++;
                if ($urandom_range(0, 39) == 0)
                    wait_results_drained();
            end
        end

        // let the last results come out
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (pending_texels.size() != 0)
            note_mismatch("result never came", pending_texels.pop_front(), 'x);

        $display("covered %0d writes, %0d reads, %0d samples, %0d ignored beats over %0d sizes",
                 writes_sent, reads_sent, samples_sent, ignored_sent, RANDOM_PHASES + 3);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
